// File: src/vmrb_pkg.sv
`default_nettype none
package vmrb_pkg;
   localparam int DefBufferDepth = 4096;
   localparam int DefMaxMessage = 64;
   localparam int DefHeaderBytes = 4;
   localparam int CfgWidth = 13;
   localparam int CfgIdxWidth = 1;
   localparam logic [CfgIdxWidth-1:0] CSR_BUFFER_SIZE = 1'd0;
   localparam logic [CfgIdxWidth-1:0] CSR_CHUNK_SIZE = 1'd1;

   localparam logic [1:0] KIND_SEND_START = 2'd0;
   localparam logic [1:0] KIND_SEND_DATA = 2'd1;
   localparam logic [1:0] KIND_RECEIVE = 2'd2;
   localparam logic [1:0] KIND_IGNORED = 2'd3;

   localparam logic [2:0] ST_SEND_OK = 3'd0;
   localparam logic [2:0] ST_WRAP_WRITTEN = 3'd1;
   localparam logic [2:0] ST_NO_ROOM = 3'd2;
   localparam logic [2:0] ST_RECEIVED = 3'd3;
   localparam logic [2:0] ST_EMPTY = 3'd4;
   localparam logic [2:0] ST_WRAP_CONSUMED = 3'd5;

   typedef struct packed {
      logic [1:0] kind;
      logic [6:0] msg_length;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [7:0] out_byte;
      logic [6:0] received_length;
      logic       last;
   } rsp_type;
endpackage
`default_nettype wire

// File: src/vmrb_if.sv
`default_nettype none
interface vmrb_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// File: src/vmrb_front.sv
`default_nettype none
module vmrb_front
   import vmrb_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   vmrb_if.sink      req,
   output logic      q_valid,
   output req_type   q_data,
   input  wire logic q_pop
);
   req_type    buf_ff [2];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;

   assign req.ready = (cnt_ff != 2'd2);
   assign push = req.valid && req.ready && (req.payload.kind != KIND_IGNORED);
   assign q_valid = (cnt_ff != 2'd0);
   assign q_data = buf_ff[rd_ff];
   assign wr_in = push ? ~wr_ff : wr_ff;
   assign rd_in = q_pop ? ~rd_ff : rd_ff;
   assign cnt_in = cnt_ff + {1'b0, push} - {1'b0, q_pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= 1'b0;
         rd_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) buf_ff[wr_ff] <= req.payload;
   end
endmodule
`default_nettype wire

// File: src/vmrb_back.sv
`default_nettype none
module vmrb_back
   import vmrb_pkg::*;
#(
   parameter int BUFFER_DEPTH = DefBufferDepth,
   parameter int MAX_MESSAGE = DefMaxMessage,
   parameter int HEADER_BYTES = DefHeaderBytes
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_write_enable,
   input  wire logic [CfgIdxWidth-1:0] csr_index,
   input  wire logic [CfgWidth-1:0]    csr_write_data,
   input  wire logic                   q_valid,
   input  wire req_type                q_data,
   output logic                        q_pop,
   vmrb_if.source                      rsp
);
   localparam int MemDepth = BUFFER_DEPTH + HEADER_BYTES;
   localparam int AW = $clog2(MemDepth + 1);
   localparam int PW = $clog2(BUFFER_DEPTH + 1);
   localparam int LW = 17;

   localparam logic [3:0] S_IDLE = 4'd0, S_DIV = 4'd1, S_HDR = 4'd2, S_RDH = 4'd3,
      S_RDW = 4'd4, S_RDC = 4'd5, S_OUT = 4'd6, S_RDB = 4'd7, S_CMT = 4'd8,
      S_RMOD = 4'd9, S_WMOD = 4'd10, S_DATA = 4'd11, S_HDRC = 4'd12, S_RCV = 4'd13;

   logic [7:0]    mem [MemDepth];
   logic [AW-1:0] maddr;
   logic [7:0]    mwdata, mrdata_ff;
   logic          mwe, mre;

   logic [12:0]   bsize_ff, chunk_ff, free_ff;
   logic [7:0]    chunkr_ff;
   logic [PW-1:0] wp_ff, rp_ff;
   logic [6:0]    left_ff;
   logic          active_ff;
   logic [3:0]    st_ff;
   logic [LW-1:0] acc_ff;
   logic [7:0]    pad_ff;
   logic [6:0]    len_ff;
   logic [15:0]   hlen_ff;
   logic [7:0]    hid_ff, hpad_ff;
   logic [4:0]    k_ff;
   logic [6:0]    n_ff, i_ff;
   logic          wrap_ff, rsp_v_ff;
   rsp_type       rsp_ff;
   logic [12:0]   size;

   assign size = (bsize_ff > 13'(BUFFER_DEPTH)) ? 13'(BUFFER_DEPTH) : bsize_ff;
   assign rsp.valid = rsp_v_ff;
   assign rsp.payload = rsp_ff;

   logic [7:0] hdr_byte;
   always_comb begin
      case (k_ff[1:0])
         2'd0: hdr_byte = wrap_ff ? 8'd0 : 8'd1;
         2'd1: hdr_byte = wrap_ff ? 8'd0 : pad_ff;
         2'd2: hdr_byte = hlen_ff[7:0];
         default: hdr_byte = hlen_ff[15:8];
      endcase
      if (k_ff > 5'd3) hdr_byte = 8'd0;
   end

   logic [LW-1:0] total, rem, tot_msg;
   logic [6:0]    ls;
   assign ls = (q_data.msg_length > 7'(MAX_MESSAGE)) ? 7'(MAX_MESSAGE) : q_data.msg_length;
   assign total = LW'(len_ff) + LW'(HEADER_BYTES) + LW'(pad_ff);
   assign rem = (13'(wp_ff) < size) ? LW'(size) - LW'(wp_ff) : '0;
   assign tot_msg = LW'(hlen_ff) + LW'(HEADER_BYTES) + LW'(hpad_ff);

   logic          busy;
   assign busy = (st_ff != S_IDLE);
   assign q_pop = q_valid && !busy && !rsp_v_ff;

   always_comb begin
      mwe = 1'b0;
      mre = 1'b0;
      maddr = '0;
      mwdata = hdr_byte;
      case (st_ff)
         S_HDR: begin
            mwe = 1'b1;
            maddr = AW'(wp_ff) + AW'(k_ff);
         end
         S_DATA: begin
            mwe = 1'b1;
            maddr = AW'(wp_ff) + AW'(HEADER_BYTES) + AW'(len_ff) - AW'(left_ff);
            mwdata = acc_ff[7:0];
         end
         S_RDH, S_CMT: begin
            mre = 1'b1;
            maddr = (st_ff == S_CMT ? AW'(wp_ff) : AW'(rp_ff)) + AW'(k_ff);
         end
         S_RDB: begin
            mre = 1'b1;
            maddr = AW'(rp_ff) + AW'(HEADER_BYTES) + AW'(i_ff);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mwe && (32'(maddr) < MemDepth)) mem[maddr[AW-1:0]] <= mwdata;
      if (mre) mrdata_ff <= (32'(maddr) < MemDepth) ? mem[maddr] : 8'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bsize_ff <= 13'd4096;
         chunkr_ff <= 8'd16;
         free_ff <= 13'd4096;
         wp_ff <= '0;
         rp_ff <= '0;
         left_ff <= '0;
         active_ff <= 1'b0;
         st_ff <= S_IDLE;
         rsp_v_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_BUFFER_SIZE: bsize_ff <= csr_write_data;
               CSR_CHUNK_SIZE: chunkr_ff <= csr_write_data[7:0];
               default: ;
            endcase
         end
         if (rsp_v_ff && rsp.ready) rsp_v_ff <= 1'b0;
         case (st_ff)
            S_IDLE: if (q_pop) begin
               rsp_ff <= '0;
               rsp_ff.last <= 1'b1;
               case (q_data.kind)
                  KIND_SEND_START: begin
                     active_ff <= 1'b0;
                     left_ff <= '0;
                     len_ff <= ls;
                     acc_ff <= LW'(ls) + LW'(HEADER_BYTES);
                     chunk_ff <= (chunkr_ff == 8'd0) ? 13'd1 : 13'(chunkr_ff);
                     st_ff <= S_DIV;
                  end
                  KIND_SEND_DATA: if (active_ff && left_ff != 7'd0) begin
                     acc_ff <= LW'(q_data.data_byte);
                     st_ff <= S_DATA;
                  end
                  default: begin
                     if (!(free_ff < size) || wp_ff == rp_ff) begin
                        rsp_ff.status <= ST_EMPTY;
                        rsp_v_ff <= 1'b1;
                     end else begin
                        k_ff <= 5'd0;
                        st_ff <= S_RDH;
                     end
                  end
               endcase
            end
            S_DIV: begin
               if (acc_ff >= LW'(chunk_ff)) acc_ff <= acc_ff - LW'(chunk_ff);
               else begin
                  pad_ff <= 8'(LW'(chunk_ff) - acc_ff);
                  st_ff <= S_HDRC;
               end
            end
            S_HDRC: begin
               k_ff <= 5'd0;
               if (total >= rem) begin
                  if (rp_ff != '0) begin
                     wrap_ff <= 1'b1;
                     hlen_ff <= 16'(rem - LW'(HEADER_BYTES));
                     free_ff <= free_ff - 13'(rem);
                     st_ff <= S_HDR;
                     rsp_ff.status <= ST_WRAP_WRITTEN;
                  end else begin
                     rsp_ff.status <= ST_NO_ROOM;
                     rsp_v_ff <= 1'b1;
                     st_ff <= S_IDLE;
                  end
               end else if (total + 1 < LW'(free_ff)) begin
                  wrap_ff <= 1'b0;
                  hlen_ff <= 16'(len_ff);
                  hpad_ff <= pad_ff;
                  st_ff <= S_HDR;
                  rsp_ff.status <= ST_SEND_OK;
               end else begin
                  rsp_ff.status <= ST_NO_ROOM;
                  rsp_v_ff <= 1'b1;
                  st_ff <= S_IDLE;
               end
            end
            S_HDR: begin
               k_ff <= k_ff + 5'd1;
               if (k_ff == 5'(HEADER_BYTES - 1)) begin
                  if (wrap_ff) begin
                     wp_ff <= '0;
                     rsp_v_ff <= 1'b1;
                     st_ff <= S_IDLE;
                  end else if (len_ff == 7'd0) begin
                     rsp_v_ff <= 1'b1;
                     acc_ff <= total;
                     st_ff <= S_WMOD;
                  end else begin
                     active_ff <= 1'b1;
                     left_ff <= len_ff;
                     rsp_v_ff <= 1'b1;
                     st_ff <= S_IDLE;
                  end
               end
            end
            S_DATA: begin
               left_ff <= left_ff - 7'd1;
               rsp_v_ff <= 1'b1;
               rsp_ff.status <= ST_SEND_OK;
               if (left_ff == 7'd1) begin
                  k_ff <= 5'd1;
                  st_ff <= S_CMT;
               end else st_ff <= S_IDLE;
            end
            S_CMT: begin
               k_ff <= k_ff + 5'd1;
               if (k_ff == 5'd2) hpad_ff <= mrdata_ff;
               if (k_ff == 5'd3) hlen_ff[7:0] <= mrdata_ff;
               if (k_ff == 5'd4) begin
                  hlen_ff[15:8] <= mrdata_ff;
                  st_ff <= S_RDW;
                  wrap_ff <= 1'b0;
               end
            end
            S_RDW: begin
               acc_ff <= tot_msg;
               st_ff <= S_WMOD;
            end
            S_WMOD: begin
               free_ff <= free_ff - 13'(acc_ff);
               active_ff <= 1'b0;
               left_ff <= '0;
               acc_ff <= LW'(wp_ff) + acc_ff;
               st_ff <= S_RMOD;
               wrap_ff <= 1'b0;
            end
            S_RMOD: begin
               if (size == 13'd0) begin
                  if (wrap_ff) rp_ff <= '0; else wp_ff <= '0;
                  st_ff <= S_IDLE;
               end else if (acc_ff >= LW'(size)) acc_ff <= acc_ff - LW'(size);
               else begin
                  if (wrap_ff) rp_ff <= PW'(acc_ff); else wp_ff <= PW'(acc_ff);
                  st_ff <= S_IDLE;
               end
            end
            S_RDH: begin
               k_ff <= k_ff + 5'd1;
               if (k_ff == 5'd1) hid_ff <= mrdata_ff;
               if (k_ff == 5'd2) hpad_ff <= mrdata_ff;
               if (k_ff == 5'd3) hlen_ff[7:0] <= mrdata_ff;
               if (k_ff == 5'd4) begin
                  hlen_ff[15:8] <= mrdata_ff;
                  st_ff <= S_RDC;
               end
            end
            S_RDC: begin
               if (hid_ff == 8'd0) begin
                  free_ff <= free_ff + 13'(16'(tot_msg));
                  rp_ff <= '0;
                  rsp_ff.status <= ST_WRAP_CONSUMED;
                  rsp_v_ff <= 1'b1;
                  st_ff <= S_IDLE;
               end else begin
                  n_ff <= (hlen_ff > 16'(MAX_MESSAGE)) ? 7'(MAX_MESSAGE) : hlen_ff[6:0];
                  i_ff <= '0;
                  if (hlen_ff == 16'd0) begin
                     rsp_ff.status <= ST_RECEIVED;
                     rsp_v_ff <= 1'b1;
                     st_ff <= S_OUT;
                  end else st_ff <= S_RDB;
               end
            end
            S_RDB: st_ff <= S_RCV;
            S_RCV: begin
               rsp_ff.status <= ST_RECEIVED;
               rsp_ff.out_byte <= mrdata_ff;
               rsp_ff.received_length <= n_ff;
               rsp_ff.last <= (i_ff + 7'd1 == n_ff);
               rsp_v_ff <= 1'b1;
               i_ff <= i_ff + 7'd1;
               st_ff <= S_OUT;
            end
            S_OUT: if (!rsp_v_ff || rsp.ready) begin
               if (i_ff == n_ff || hlen_ff == 16'd0) begin
                  free_ff <= free_ff + 13'(tot_msg);
                  acc_ff <= LW'(rp_ff) + tot_msg;
                  wrap_ff <= 1'b1;
                  st_ff <= S_RMOD;
               end else if (rsp_v_ff) st_ff <= S_RDB;
            end
            default: st_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

// File: src/variable_message_ring_buffer_unit.sv
// Variable-length message ring buffer.
// req channel carries kind, msg_length and data_byte; kind 0 starts a send,
// kind 1 writes one data byte, kind 2 receives one message, kind 3 is dropped.
// rsp channel returns status, out_byte, received_length and last; a receive
// returns one result per message byte, everything else at most one result.
// csr port writes buffer_size (index 0) and chunk_size (index 1); the user
// must write them only while idle, which the block itself does not enforce.
// A two-entry request queue decouples the front from the back engine, which
// owns the single byte-wide ring memory port.
// Send start finds the padding by serial subtraction of the chunk size; the
// commit and receive paths wrap pointers by serial subtraction of the size.
// Reset clears pointers, free count and queue; memory is not cleared.
// A stalled rsp holds the back engine; the queue then fills and req.ready drops.
`default_nettype none
module variable_message_ring_buffer_unit
   import vmrb_pkg::*;
#(
   parameter int BUFFER_DEPTH = DefBufferDepth,
   parameter int MAX_MESSAGE = DefMaxMessage,
   parameter int HEADER_BYTES = DefHeaderBytes
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_write_enable,
   input  wire logic [CfgIdxWidth-1:0] csr_index,
   input  wire logic [CfgWidth-1:0]    csr_write_data,
   vmrb_if.sink                        req,
   vmrb_if.source                      rsp
);
   logic    q_valid, q_pop;
   req_type q_data;

   vmrb_front u_front (
      .clock(clock), .reset(reset), .req(req),
      .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop)
   );

   vmrb_back #(
      .BUFFER_DEPTH(BUFFER_DEPTH), .MAX_MESSAGE(MAX_MESSAGE), .HEADER_BYTES(HEADER_BYTES)
   ) u_back (
      .clock(clock), .reset(reset), .csr_write_enable(csr_write_enable),
      .csr_index(csr_index), .csr_write_data(csr_write_data),
      .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop), .rsp(rsp)
   );
endmodule
`default_nettype wire

// File: src/vmrb_checker.sv
`default_nettype none
module vmrb_checker
   import vmrb_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_payload
);
   a_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_payload))
      else $error("rsp payload changed while stalled");
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.status <= ST_WRAP_CONSUMED)
      else $error("bad status");
   a_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status != ST_RECEIVED |-> rsp_payload.last)
      else $error("non-receive result without last");
endmodule

bind variable_message_ring_buffer_unit vmrb_checker u_chk (
   .clock(clock), .reset(reset), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_payload(rsp.payload)
);
`default_nettype wire

// File: dv/tb.sv
`timescale 1ns / 100ps
module tb;
   import vmrb_pkg::*;

   localparam int MemDepth = DefBufferDepth + DefHeaderBytes;
   localparam int CycleLimit = 1000000;
   localparam int SettleCycles = 5000;

   class ring_scoreboard;
      bit [7:0] mem [MemDepth];
      bit written [MemDepth];
      int unsigned wr_ptr, rd_ptr, free_cnt, send_left, buf_reg, chunk_reg;
      bit sending;
      rsp_type pending [$];
      int failures;

      function new();
         wr_ptr = 0;
         rd_ptr = 0;
         free_cnt = 4096;
         send_left = 0;
         sending = 0;
         buf_reg = 4096;
         chunk_reg = 16;
         failures = 0;
      endfunction

      function int unsigned used_bytes();
         return buf_reg > DefBufferDepth ? DefBufferDepth : buf_reg;
      endfunction

      function void store(int unsigned a, int unsigned v);
         if (a < MemDepth) begin
            mem[a] = v[7:0];
            written[a] = 1;
         end
      endfunction

      function int unsigned fetch(int unsigned a);
         return a < MemDepth ? int'(mem[a]) : 0;
      endfunction

      function int unsigned stored_length(int unsigned a);
         return fetch(a + 2) | (fetch(a + 3) << 8);
      endfunction

      function void put_header(int unsigned a, int unsigned id, int unsigned pad,
                               int unsigned len);
         store(a, id);
         store(a + 1, pad);
         store(a + 2, len & 8'hFF);
         store(a + 3, (len >> 8) & 8'hFF);
      endfunction

      function void push(logic [2:0] st, int unsigned b, int unsigned len, bit fin);
         rsp_type r;
         r.status = st;
         r.out_byte = b[7:0];
         r.received_length = len[6:0];
         r.last = fin;
         pending.push_back(r);
      endfunction

      function void commit_message();
         int unsigned size, total;
         size = used_bytes();
         total = stored_length(wr_ptr) + DefHeaderBytes + fetch(wr_ptr + 1);
         free_cnt = (free_cnt - total) & 13'h1FFF;
         wr_ptr = size != 0 ? (wr_ptr + total) % size : 0;
         sending = 0;
         send_left = 0;
      endfunction

      function void write_config(logic [CfgIdxWidth-1:0] idx, int unsigned v);
         if (idx == CSR_BUFFER_SIZE) buf_reg = v & 13'h1FFF;
         else chunk_reg = v & 8'hFF;
      endfunction

      function bit receive_is_safe();
         int unsigned size, len, n;
         size = used_bytes();
         if (!(free_cnt < size) || wr_ptr == rd_ptr) return 1;
         for (int k = 0; k < DefHeaderBytes; k++)
            if (!written[rd_ptr + k]) return 0;
         if (fetch(rd_ptr) == 0) return 1;
         len = stored_length(rd_ptr);
         n = len > DefMaxMessage ? DefMaxMessage : len;
         for (int unsigned i = 0; i < n; i++)
            if (rd_ptr + DefHeaderBytes + i < MemDepth &&
                !written[rd_ptr + DefHeaderBytes + i]) return 0;
         return 1;
      endfunction

      function void note_request(req_type q);
         int unsigned size, len, chunk, pad, total, room, offset, n;
         size = used_bytes();
         case (q.kind)
            KIND_SEND_START: begin
               len = q.msg_length > DefMaxMessage ? DefMaxMessage : q.msg_length;
               chunk = chunk_reg != 0 ? chunk_reg : 1;
               pad = chunk - ((len + DefHeaderBytes) % chunk);
               total = len + DefHeaderBytes + pad;
               room = wr_ptr < size ? size - wr_ptr : 0;
               sending = 0;
               send_left = 0;
               if (total >= room) begin
                  if (rd_ptr != 0) begin
                     put_header(wr_ptr, 0, 0, (room - DefHeaderBytes) & 16'hFFFF);
                     free_cnt = (free_cnt - room) & 13'h1FFF;
                     wr_ptr = 0;
                     push(ST_WRAP_WRITTEN, 0, 0, 1);
                  end else begin
                     push(ST_NO_ROOM, 0, 0, 1);
                  end
               end else if (total + 1 < free_cnt) begin
                  put_header(wr_ptr, 1, pad, len);
                  if (len == 0) begin
                     commit_message();
                  end else begin
                     sending = 1;
                     send_left = len;
                  end
                  push(ST_SEND_OK, 0, 0, 1);
               end else begin
                  push(ST_NO_ROOM, 0, 0, 1);
               end
            end
            KIND_SEND_DATA: begin
               if (sending && send_left != 0) begin
                  len = stored_length(wr_ptr);
                  offset = len >= send_left ? len - send_left : 0;
                  store(wr_ptr + DefHeaderBytes + offset, q.data_byte);
                  send_left--;
                  if (send_left == 0) commit_message();
                  push(ST_SEND_OK, 0, 0, 1);
               end
            end
            KIND_RECEIVE: begin
               if (!(free_cnt < size) || wr_ptr == rd_ptr) begin
                  push(ST_EMPTY, 0, 0, 1);
               end else begin
                  pad = fetch(rd_ptr + 1);
                  len = stored_length(rd_ptr);
                  if (fetch(rd_ptr) == 0) begin
                     free_cnt = (free_cnt + ((len + DefHeaderBytes + pad) & 16'hFFFF))
                                & 13'h1FFF;
                     rd_ptr = 0;
                     push(ST_WRAP_CONSUMED, 0, 0, 1);
                  end else begin
                     n = len > DefMaxMessage ? DefMaxMessage : len;
                     if (n == 0) push(ST_RECEIVED, 0, 0, 1);
                     for (int unsigned i = 0; i < n; i++)
                        push(ST_RECEIVED, fetch(rd_ptr + DefHeaderBytes + i), n, i + 1 == n);
                     rd_ptr = (rd_ptr + len + DefHeaderBytes + pad) % size;
                     free_cnt = (free_cnt + len + DefHeaderBytes + pad) & 13'h1FFF;
                  end
               end
            end
            default: ;
         endcase
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            failures++;
            if (failures <= 10) $display("unexpected result %p", got);
         end else begin
            want = pending.pop_front();
            if (got !== want) begin
               failures++;
               if (failures <= 10) $display("mismatch: expected %p actual %p", want, got);
            end
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic csr_write_enable = 0;
   logic [CfgIdxWidth-1:0] csr_index = CSR_BUFFER_SIZE;
   logic [CfgWidth-1:0] csr_write_data = '0;
   int cycles = 0;
   int stall_left = 0;
   bit steady_sink = 0;
   int req_count = 0;
   ring_scoreboard sb = new();

   vmrb_if #(.payload_type(req_type)) req_if ();
   vmrb_if #(.payload_type(rsp_type)) rsp_if ();

   variable_message_ring_buffer_unit dut (
      .clock(clock),
      .reset(reset),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .req(req_if.sink),
      .rsp(rsp_if.source)
   );

   initial begin
      req_if.valid = 0;
      req_if.payload = '0;
      rsp_if.ready = 1;
   end

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CycleLimit) begin
         $display("Verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         sb.check_result(rsp_if.payload);
         if ($urandom_range(0, 31) == 0) steady_sink = ~steady_sink;
         stall_left = steady_sink ? 0 : $urandom_range(0, 9);
         if (stall_left > 0) rsp_if.ready <= 0;
      end else if (stall_left > 0) begin
         stall_left--;
         if (stall_left == 0) rsp_if.ready <= 1;
      end
   end

   task automatic drive_request(req_type q);
      int gap;
      if (q.kind == KIND_RECEIVE && !sb.receive_is_safe()) begin
         q.kind = KIND_SEND_START;
         q.msg_length = 0;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
      if (gap > 0 && req_if.valid) req_if.valid <= 0;
      repeat (gap) @(posedge clock);
      req_if.valid <= 1;
      req_if.payload <= q;
      do @(posedge clock); while (!req_if.ready);
      sb.note_request(q);
      if (q.kind != KIND_IGNORED) req_count++;
   endtask

   task automatic drive(logic [1:0] kind, int unsigned len, int unsigned b);
      req_type q;
      q.kind = kind;
      q.msg_length = len[6:0];
      q.data_byte = b[7:0];
      drive_request(q);
   endtask

   task automatic send_message(int unsigned len, bit cut);
      int unsigned stop;
      stop = cut ? $urandom_range(0, len) : len;
      drive(KIND_SEND_START, len, $urandom);
      for (int unsigned i = 0; i < stop && i < DefMaxMessage; i++)
         drive(KIND_SEND_DATA, $urandom, $urandom);
   endtask

   task automatic settle();
      if (req_if.valid) req_if.valid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_csr(logic [CfgIdxWidth-1:0] idx, int unsigned v);
      @(posedge clock);
      csr_write_enable <= 1;
      csr_index <= idx;
      csr_write_data <= v[CfgWidth-1:0];
      @(posedge clock);
      csr_write_enable <= 0;
      sb.write_config(idx, v);
   endtask

   task automatic random_traffic(int items);
      int stop_at, pick;
      stop_at = req_count + items;
      while (req_count < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 55)
            send_message($urandom_range(0, 7) == 0 ? $urandom_range(0, 64)
                                                    : $urandom_range(0, 12),
                         $urandom_range(0, 19) == 0);
         else if (pick < 85) drive(KIND_RECEIVE, $urandom, $urandom);
         else if (pick < 91) drive(KIND_SEND_DATA, $urandom, $urandom);
         else if (pick < 95) drive(KIND_IGNORED, $urandom, $urandom);
         else drive(KIND_SEND_START, $urandom_range(65, 127), $urandom);
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 0;
      write_csr(CSR_BUFFER_SIZE, 4096);
      write_csr(CSR_CHUNK_SIZE, 16);

      drive(KIND_RECEIVE, 0, 0);
      drive(KIND_SEND_DATA, 0, 8'hFF);
      drive(KIND_IGNORED, 7'h7F, 8'hFF);
      send_message(0, 0);
      drive(KIND_RECEIVE, 0, 0);
      drive(KIND_SEND_START, 3, 0);
      drive(KIND_SEND_DATA, 0, 8'h00);
      drive(KIND_SEND_DATA, 0, 8'hFF);
      drive(KIND_SEND_DATA, 0, 8'hA5);
      drive(KIND_SEND_START, 2, 0);
      drive(KIND_SEND_DATA, 0, 8'h5A);
      drive(KIND_SEND_START, 7'h7F, 0);
      drive(KIND_SEND_START, 1, 0);
      drive(KIND_SEND_DATA, 7'h7F, 8'h80);
      drive(KIND_RECEIVE, 0, 0);
      drive(KIND_RECEIVE, 0, 0);
      drive(KIND_RECEIVE, 0, 0);
      send_message(64, 0);
      drive(KIND_RECEIVE, 0, 0);
      random_traffic(15);
      settle();

      write_csr(CSR_CHUNK_SIZE, 255);
      random_traffic(12);
      settle();
      write_csr(CSR_CHUNK_SIZE, 1);
      random_traffic(10);
      settle();
      write_csr(CSR_CHUNK_SIZE, 0);
      write_csr(CSR_BUFFER_SIZE, 8191);
      random_traffic(10);
      settle();
      write_csr(CSR_BUFFER_SIZE, 64);
      write_csr(CSR_CHUNK_SIZE, 4);
      random_traffic(10);
      settle();
      write_csr(CSR_BUFFER_SIZE, 4096);
      write_csr(CSR_CHUNK_SIZE, 16);
      random_traffic(10);
      settle();

      if (sb.failures == 0 && sb.pending.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule
